### sv/deiq_pkg.sv
// Package for the debounced edge interrupt qualifier.
// Holds the word types, register and action codes shared by all files.
// No dependencies.
package deiq_pkg;

	localparam int TIME_W     = 32;
	localparam int CNT_W      = 32;
	localparam int DEBOUNCE_W = 19;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_CLEAR   = 2'd1,
		ACT_ENABLE  = 2'd2,
		ACT_DISABLE = 2'd3
	} action_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF     = 2'd0,
		MODE_RISING  = 2'd1,
		MODE_FALLING = 2'd2,
		MODE_ANY     = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRIGGER_MODE    = 2'd0,
		CFG_DEBOUNCE_US     = 2'd1,
		CFG_HANDLER_PRESENT = 2'd2
	} cfg_reg_t;

	// One input word.
	typedef struct packed {
		logic [1:0] action;
		logic       pin_level;
		logic       sched_accept;
	} item_t;

	// One result word.
	typedef struct packed {
		logic              callback_request;
		logic              irq_armed;
		logic              debounce_busy;
		logic              event_level;
		logic [TIME_W-1:0] event_time;
		logic [CNT_W-1:0]  event_count;
		logic [CNT_W-1:0]  scheduled_count;
		logic [CNT_W-1:0]  missed_count;
		logic [CNT_W-1:0]  glitch_count;
	} result_t;

	// Configuration register contents.
	typedef struct packed {
		logic [MODE_W-1:0]     trigger_mode;
		logic [DEBOUNCE_W-1:0] debounce_us;
		logic                  handler_present;
	} cfg_t;

endpackage

### sv/deiq_if.sv
// Valid/ready channel interfaces for the input words and result words.
// Depends on deiq_pkg for the payload types.
interface deiq_item_if;
	logic            valid;
	logic            ready;
	deiq_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface deiq_result_if;
	logic              valid;
	logic              ready;
	deiq_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/deiq_cfg_regs.sv
// Configuration registers of the qualifier, written through a plain write port.
// Depends on deiq_pkg.
module deiq_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [deiq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [deiq_pkg::DEBOUNCE_W-1:0]     cfg_data,
	output deiq_pkg::cfg_t                      cfg
);

	deiq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				deiq_pkg::CFG_TRIGGER_MODE: begin
					cfg_q.trigger_mode <= cfg_data[deiq_pkg::MODE_W-1:0];
				end
				deiq_pkg::CFG_DEBOUNCE_US: begin
					cfg_q.debounce_us <= cfg_data;
				end
				deiq_pkg::CFG_HANDLER_PRESENT: begin
					cfg_q.handler_present <= cfg_data[0];
				end
				default: begin
					// Unused index: the write is dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/deiq_in_stage.sv
// Input register stage: holds one accepted word until the core consumes it.
// Depends on deiq_pkg and deiq_if.
module deiq_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	deiq_item_if.sink         item,
	input  logic              advance,
	output logic              valid_s1,
	output deiq_pkg::item_t   item_s1
);

	logic load;

	assign item.ready = !valid_s1 || advance;
	assign load       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item.data;
		end
	end

endmodule

### sv/deiq_core.sv
// Edge qualification, debounce timing and event counters.
// State advances once per consumed word; the result word is the state after it.
// Depends on deiq_pkg.
module deiq_core (
	input  logic              clk,
	input  logic              arst_n,
	input  deiq_pkg::cfg_t    cfg,
	input  logic              advance,
	input  deiq_pkg::item_t   item_s1,
	output deiq_pkg::result_t result
);

	typedef struct packed {
		logic [deiq_pkg::TIME_W-1:0] time_now;
		logic                        prev_sample;
		logic                        ref_level_valid;
		logic                        ref_level;
		logic                        captured_level;
		logic [deiq_pkg::TIME_W-1:0] last_edge_time;
		logic [deiq_pkg::TIME_W-1:0] wait_start_time;
		logic                        in_debounce;
		logic                        irq_enable;
		logic [deiq_pkg::CNT_W-1:0]  accepted_total;
		logic [deiq_pkg::CNT_W-1:0]  scheduled_total;
		logic [deiq_pkg::CNT_W-1:0]  missed_total;
		logic [deiq_pkg::CNT_W-1:0]  glitch_total;
	} state_t;

	state_t st_q;
	state_t st_d;
	logic   req;
	logic   edge_hit;
	logic   done;
	logic   passed;
	logic   pin;
	logic [deiq_pkg::TIME_W-1:0] since_edge;
	logic [deiq_pkg::TIME_W-1:0] since_start;
	logic [deiq_pkg::TIME_W-1:0] quiet_limit;
	logic [deiq_pkg::TIME_W-1:0] cap_limit;

	assign pin         = item_s1.pin_level;
	assign quiet_limit = {{(deiq_pkg::TIME_W-deiq_pkg::DEBOUNCE_W){1'b0}}, cfg.debounce_us};
	assign cap_limit   = {{(deiq_pkg::TIME_W-deiq_pkg::DEBOUNCE_W-1){1'b0}},
		cfg.debounce_us, 1'b0};

	always_comb begin
		st_d        = st_q;
		req         = 1'b0;
		edge_hit    = 1'b0;
		done        = 1'b0;
		passed      = 1'b0;
		since_edge  = '0;
		since_start = '0;

		unique case (item_s1.action)
			deiq_pkg::ACT_TICK: begin
				st_d.time_now = st_q.time_now + 32'd1;

				if (st_q.irq_enable && (pin != st_q.prev_sample)) begin
					unique case (cfg.trigger_mode)
						deiq_pkg::MODE_RISING:  edge_hit = pin;
						deiq_pkg::MODE_FALLING: edge_hit = !pin;
						deiq_pkg::MODE_ANY:     edge_hit = 1'b1;
						default:                edge_hit = 1'b0;
					endcase
				end

				// In any-edge mode a level equal to the last accepted one is dropped.
				if (edge_hit && (cfg.trigger_mode == deiq_pkg::MODE_ANY)) begin
					if (st_q.ref_level_valid && (pin == st_q.ref_level)) begin
						edge_hit = 1'b0;
					end else begin
						st_d.ref_level       = pin;
						st_d.ref_level_valid = 1'b1;
					end
				end

				if (edge_hit) begin
					st_d.captured_level = pin;
					st_d.last_edge_time = st_d.time_now;
					if (st_q.in_debounce) begin
						st_d.glitch_total = st_q.glitch_total + 32'd1;
					end else begin
						st_d.accepted_total = st_q.accepted_total + 32'd1;
						if (cfg.debounce_us != '0) begin
							st_d.wait_start_time = st_d.time_now;
							st_d.glitch_total    = '0;
							st_d.in_debounce     = 1'b1;
						end else if (cfg.handler_present) begin
							req             = item_s1.sched_accept;
							st_d.irq_enable = 1'b0;
							if (item_s1.sched_accept) begin
								st_d.scheduled_total = st_q.scheduled_total + 32'd1;
							end else begin
								st_d.missed_total = st_q.missed_total + 32'd1;
							end
						end else begin
							st_d.missed_total = st_q.missed_total + 32'd1;
						end
					end
				end else if (st_q.in_debounce) begin
					since_edge  = st_d.time_now - st_q.last_edge_time;
					since_start = st_d.time_now - st_q.wait_start_time;
					if (since_edge > quiet_limit) begin
						unique case (cfg.trigger_mode)
							deiq_pkg::MODE_RISING:  passed = pin;
							deiq_pkg::MODE_FALLING: passed = !pin;
							deiq_pkg::MODE_ANY:     passed = (pin == st_q.ref_level);
							default:                passed = 1'b0;
						endcase
						st_d.last_edge_time = st_d.time_now;
						done                = 1'b1;
					end else if (since_start > cap_limit) begin
						done = 1'b1;
					end

					if (done) begin
						st_d.in_debounce = 1'b0;
						if (passed && cfg.handler_present) begin
							req             = item_s1.sched_accept;
							st_d.irq_enable = 1'b0;
							if (item_s1.sched_accept) begin
								st_d.scheduled_total = st_q.scheduled_total + 32'd1;
							end else begin
								st_d.missed_total = st_q.missed_total + 32'd1;
							end
						end else begin
							st_d.irq_enable = 1'b1;
						end
					end
				end

				st_d.prev_sample = pin;
			end
			deiq_pkg::ACT_CLEAR: begin
				st_d.accepted_total  = '0;
				st_d.scheduled_total = '0;
				st_d.missed_total    = '0;
				st_d.glitch_total    = '0;
				st_d.irq_enable      = 1'b1;
			end
			deiq_pkg::ACT_ENABLE: begin
				st_d.irq_enable = 1'b1;
			end
			deiq_pkg::ACT_DISABLE: begin
				st_d.irq_enable = 1'b0;
			end
			default: begin
				st_d = st_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= '0;
			st_q.irq_enable <= 1'b1;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

	always_comb begin
		result.callback_request = req;
		result.irq_armed        = st_d.irq_enable;
		result.debounce_busy    = st_d.in_debounce;
		result.event_level      = st_d.captured_level;
		result.event_time       = st_d.last_edge_time;
		result.event_count      = st_d.accepted_total;
		result.scheduled_count  = st_d.scheduled_total;
		result.missed_count     = st_d.missed_total;
		result.glitch_count     = st_d.glitch_total;
	end

endmodule

### sv/deiq_out_reg.sv
// Result register: holds one finished word until the receiver takes it.
// Depends on deiq_pkg and deiq_if.
module deiq_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  deiq_pkg::result_t result_d,
	output logic              advance,
	deiq_result_if.source     result
);

	logic valid_s2;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign result.valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.data <= result_d;
		end
	end

endmodule

### sv/debounced_edge_interrupt_qualifier.sv
// Debounced edge interrupt qualifier for one input pin.
// Top level: ties together the config registers, input stage, core and result register.
// Depends on deiq_pkg, deiq_if and the deiq_* modules.
//
// Usage:
// Words arrive on the item channel (valid/ready). A tick word samples the pin and
// advances the microsecond time base by one; the other actions clear the counters or
// enable or disable the interrupt. Every accepted word produces exactly one result word
// on the result channel, carrying the callback request pulse and the state after the word.
// The configuration port writes trigger mode, debounce time and handler presence;
// it should only be written while no word is in flight.
//
// Timing: a word accepted from the item channel is registered in the input stage,
// processed by the core and lands in the result register. The core takes one word per
// cycle unless the receiver stalls, so throughput is one word per clock.
//
// Reset (arst_n low) clears all state and counters, arms the interrupt and clears the
// configuration. When the receiver stalls, the result register holds its word and
// the input stage still takes one more word, after which item.ready drops until the
// result word is taken.
module debounced_edge_interrupt_qualifier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [deiq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [deiq_pkg::DEBOUNCE_W-1:0] cfg_data,
	deiq_item_if.sink                       item,
	deiq_result_if.source                   result
);

	deiq_pkg::cfg_t    cfg;
	deiq_pkg::item_t   item_s1;
	deiq_pkg::result_t result_d;
	logic              valid_s1;
	logic              advance;

	deiq_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register: frees the item channel while a result waits downstream.
	deiq_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// The core updates its state only on the cycle the word moves into the result register.
	deiq_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result_d)
	);

	deiq_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.result_d (result_d),
		.advance  (advance),
		.result   (result)
	);

endmodule

### verif/tb.sv
// Self-checking testbench for debounced_edge_interrupt_qualifier.
// Drives tick and control words, predicts each status word in-line and checks every field.
// Depends on deiq_pkg, deiq_if and the RTL of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import deiq_pkg::*;

	// The block decodes indexes 0 to 2 only. A write to the last index must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MAX = '1;
	localparam int LONG_HOLD = 48;
	localparam int PHASES = 12;

	// One row of the directed table: either a register write or a word.
	// Rows marked typed carry a status word that can be read off directly.
	typedef struct {
		bit                    is_write;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [DEBOUNCE_W-1:0] reg_val;
		item_t                 word;
		bit                    typed;
		result_t               want;
	} step_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DEBOUNCE_W-1:0] cfg_data;

	deiq_item_if item_ch ();
	deiq_result_if result_ch ();

	debounced_edge_interrupt_qualifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	// Register copies as the block should hold them.
	mode_t                 cur_mode;
	logic [DEBOUNCE_W-1:0] cur_debounce;
	bit                    cur_handler;

	// Pin qualifier state, kept in step with the block.
	logic [TIME_W-1:0] now_us;
	logic [TIME_W-1:0] edge_us;
	logic [TIME_W-1:0] wait_start_us;
	bit                last_pin;
	bit                ref_ok;
	bit                ref_pin;
	bit                held_level;
	bit                waiting;
	bit                armed;
	logic [CNT_W-1:0]  n_accepted;
	logic [CNT_W-1:0]  n_scheduled;
	logic [CNT_W-1:0]  n_missed;
	logic [CNT_W-1:0]  n_glitch;

	// Status words the block still owes, oldest first.
	result_t pending_status[$];
	int      mismatch_count;

	// Set while a register write is being driven, so the next word lowers the enable.
	bit writing;
	// Shared with the receiver: a request for one long stall, and a no-idling stretch.
	bit hold_request;
	bit no_idle;

	step_t directed_steps[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offers an event to the callback scheduler. It either takes it now or the event is lost.
	function automatic bit hand_to_scheduler(bit take);
		if (take) begin
			n_scheduled = n_scheduled + 1;
			return 1'b1;
		end
		n_missed = n_missed + 1;
		return 1'b0;
	endfunction

	// Works out the status word that one accepted word must produce and moves the
	// qualifier state on by that word.
	function automatic result_t qualify_pin_word(item_t w);
		result_t r;
		bit req;
		bit hit;
		bit done;
		bit level_ok;
		logic [TIME_W-1:0] quiet_span;
		logic [TIME_W-1:0] wait_span;
		req = 1'b0;
		case (w.action)
			ACT_TICK: begin
				// The time base moves first; everything below sees the new time.
				now_us = now_us + 1;
				hit = 1'b0;
				if (armed && w.pin_level != last_pin) begin
					case (cur_mode)
						MODE_RISING:  hit = w.pin_level;
						MODE_FALLING: hit = !w.pin_level;
						MODE_ANY:     hit = 1'b1;
						default:      hit = 1'b0;
					endcase
				end
				// In any-edge mode a change back to the level accepted last is dropped.
				if (hit && cur_mode == MODE_ANY) begin
					if (ref_ok && w.pin_level == ref_pin) begin
						hit = 1'b0;
					end else begin
						ref_pin = w.pin_level;
						ref_ok = 1'b1;
					end
				end
				if (hit) begin
					held_level = w.pin_level;
					edge_us = now_us;
					if (waiting) begin
						n_glitch = n_glitch + 1;
					end else begin
						n_accepted = n_accepted + 1;
						if (cur_debounce != '0) begin
							wait_start_us = now_us;
							n_glitch = '0;
							waiting = 1'b1;
						end else if (cur_handler) begin
							req = hand_to_scheduler(w.sched_accept);
							armed = 1'b0;
						end else begin
							n_missed = n_missed + 1;
						end
					end
				end else if (waiting) begin
					done = 1'b0;
					level_ok = 1'b0;
					// Both spans wrap modulo 2^32, so the compares survive a time base wrap.
					quiet_span = now_us - edge_us;
					wait_span = now_us - wait_start_us;
					if (quiet_span > {13'd0, cur_debounce}) begin
						case (cur_mode)
							MODE_RISING:  level_ok = w.pin_level;
							MODE_FALLING: level_ok = !w.pin_level;
							MODE_ANY:     level_ok = (w.pin_level == ref_pin);
							default:      level_ok = 1'b0;
						endcase
						edge_us = now_us;
						done = 1'b1;
					end else if (wait_span > {12'd0, cur_debounce, 1'b0}) begin
						// The pin never settled within twice the quiet time.
						done = 1'b1;
					end
					if (done) begin
						waiting = 1'b0;
						// A missing handler here is not counted as a missed event.
						if (level_ok && cur_handler) begin
							req = hand_to_scheduler(w.sched_accept);
							armed = 1'b0;
						end else begin
							armed = 1'b1;
						end
					end
				end
				last_pin = w.pin_level;
			end
			ACT_CLEAR: begin
				n_accepted = '0;
				n_scheduled = '0;
				n_missed = '0;
				n_glitch = '0;
				armed = 1'b1;
			end
			ACT_ENABLE:  armed = 1'b1;
			ACT_DISABLE: armed = 1'b0;
			default: ;
		endcase
		r.callback_request = req;
		r.irq_armed = armed;
		r.debounce_busy = waiting;
		r.event_level = held_level;
		r.event_time = edge_us;
		r.event_count = n_accepted;
		r.scheduled_count = n_scheduled;
		r.missed_count = n_missed;
		r.glitch_count = n_glitch;
		return r;
	endfunction

	function automatic step_t word_step(action_t a, bit pin, bit take);
		step_t s;
		s = '{default: '0};
		s.word.action = a;
		s.word.pin_level = pin;
		s.word.sched_accept = take;
		return s;
	endfunction

	// A word whose status is all zero apart from the interrupt enable.
	function automatic step_t checked_step(action_t a, bit pin, bit take, bit irq_on);
		step_t s;
		s = word_step(a, pin, take);
		s.typed = 1'b1;
		s.want = '0;
		s.want.irq_armed = irq_on;
		return s;
	endfunction

	function automatic step_t write_step(logic [CFG_IDX_W-1:0] idx,
			logic [DEBOUNCE_W-1:0] val);
		step_t s;
		s = '{default: '0};
		s.is_write = 1'b1;
		s.reg_idx = idx;
		s.reg_val = val;
		return s;
	endfunction

	task automatic drain_status();
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	// Registers change only with nothing in flight. Every word yields a status word, so
	// the block is idle as soon as the last one has been taken.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DEBOUNCE_W-1:0] val);
		if (!writing) drain_status();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		writing = 1'b1;
		case (idx)
			CFG_TRIGGER_MODE:    cur_mode = mode_t'(val[MODE_W-1:0]);
			CFG_DEBOUNCE_US:     cur_debounce = val;
			CFG_HANDLER_PRESENT: cur_handler = val[0];
			default: ;
		endcase
	endtask

	// Offers one word until it is taken. A gap of zero keeps valid high, so the caller
	// must offer the next word in the same step; any other gap drops valid for that long.
	task automatic send_word(item_t w, bit typed, result_t want, int gap);
		result_t predicted;
		if (writing) begin
			cfg_write <= 1'b0;
			writing = 1'b0;
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= w;
		do @(posedge clk); while (!item_ch.ready);
		predicted = qualify_pin_word(w);
		pending_status.push_back(typed ? want : predicted);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Every status word taken by the receiver is checked against the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (pending_status.size() == 0) begin
				$display("%0t ns: status word with nothing expected, got %h", $time, got);
				mismatch_count++;
			end else begin
				want = pending_status.pop_front();
				check_field("callback_request", 32'(want.callback_request),
					32'(got.callback_request));
				check_field("irq_armed", 32'(want.irq_armed), 32'(got.irq_armed));
				check_field("debounce_busy", 32'(want.debounce_busy),
					32'(got.debounce_busy));
				check_field("event_level", 32'(want.event_level), 32'(got.event_level));
				check_field("event_time", want.event_time, got.event_time);
				check_field("event_count", want.event_count, got.event_count);
				check_field("scheduled_count", want.scheduled_count, got.scheduled_count);
				check_field("missed_count", want.missed_count, got.missed_count);
				check_field("glitch_count", want.glitch_count, got.glitch_count);
			end
		end
	end

	// Receiver. It may draw a random stall before each status word, none during
	// no-idling stretches, and once in a while holds ready low long enough for the input
	// stage to fill and push back on the sender.
	initial begin
		int gap;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			gap = no_idle ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	// Overall watchdog, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int p;
		int n;
		int words;
		int gap;
		int r;
		int run_left;
		int run_max;
		bit pin_now;
		bit stall_phase;
		item_t w;
		mode_t mode;
		logic [DEBOUNCE_W-1:0] deb;
		logic [DEBOUNCE_W-1:0] mode_val;
		logic [DEBOUNCE_W-1:0] hnd_val;
		bit hnd;

		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		hold_request = 1'b0;
		no_idle = 1'b0;
		writing = 1'b0;
		mismatch_count = 0;

		// State after reset: everything cleared, interrupt armed.
		cur_mode = MODE_OFF;
		cur_debounce = '0;
		cur_handler = 1'b0;
		now_us = '0;
		edge_us = '0;
		wait_start_us = '0;
		last_pin = 1'b0;
		ref_ok = 1'b0;
		ref_pin = 1'b0;
		held_level = 1'b0;
		waiting = 1'b0;
		armed = 1'b1;
		n_accepted = '0;
		n_scheduled = '0;
		n_missed = '0;
		n_glitch = '0;

		// Straight out of reset with the mode off nothing can qualify, so only the
		// interrupt enable moves.
		directed_steps.push_back(checked_step(ACT_TICK, 1'b0, 1'b0, 1'b1));
		directed_steps.push_back(checked_step(ACT_DISABLE, 1'b1, 1'b1, 1'b0));
		directed_steps.push_back(checked_step(ACT_ENABLE, 1'b0, 1'b0, 1'b1));
		directed_steps.push_back(checked_step(ACT_TICK, 1'b1, 1'b1, 1'b1));
		// Rising mode with a handler and no debounce: a taken event disarms the interrupt,
		// and edges while disarmed are ignored until a clear re-arms it.
		directed_steps.push_back(write_step(CFG_TRIGGER_MODE, 19'h7FFFC | MODE_RISING));
		directed_steps.push_back(write_step(CFG_HANDLER_PRESENT, 19'h1));
		directed_steps.push_back(word_step(ACT_TICK, 1'b0, 1'b1));
		directed_steps.push_back(word_step(ACT_TICK, 1'b1, 1'b1));
		directed_steps.push_back(word_step(ACT_TICK, 1'b0, 1'b0));
		directed_steps.push_back(word_step(ACT_TICK, 1'b1, 1'b1));
		directed_steps.push_back(word_step(ACT_CLEAR, 1'b1, 1'b0));
		directed_steps.push_back(word_step(ACT_TICK, 1'b0, 1'b0));
		directed_steps.push_back(word_step(ACT_TICK, 1'b1, 1'b0));
		// Any-edge mode without a handler. A return to the level accepted last, after the
		// opposite edge was hidden by a disable, must be rejected.
		directed_steps.push_back(write_step(CFG_TRIGGER_MODE, DEBOUNCE_W'(MODE_ANY)));
		directed_steps.push_back(write_step(CFG_HANDLER_PRESENT, 19'h7FFFE));
		directed_steps.push_back(write_step(CFG_UNUSED, DEBOUNCE_MAX));
		directed_steps.push_back(word_step(ACT_ENABLE, 1'b0, 1'b0));
		directed_steps.push_back(word_step(ACT_TICK, 1'b0, 1'b1));
		directed_steps.push_back(word_step(ACT_DISABLE, 1'b0, 1'b1));
		directed_steps.push_back(word_step(ACT_TICK, 1'b1, 1'b0));
		directed_steps.push_back(word_step(ACT_ENABLE, 1'b1, 1'b0));
		directed_steps.push_back(word_step(ACT_TICK, 1'b0, 1'b1));
		// Debounce of two: a rising edge opens the wait, a bounce counts as a glitch, and
		// three quiet ticks at high level pass the check and request the callback.
		directed_steps.push_back(write_step(CFG_TRIGGER_MODE, DEBOUNCE_W'(MODE_RISING)));
		directed_steps.push_back(write_step(CFG_DEBOUNCE_US, 19'd2));
		directed_steps.push_back(write_step(CFG_HANDLER_PRESENT, 19'h1));
		directed_steps.push_back(word_step(ACT_TICK, 1'b1, 1'b0));
		directed_steps.push_back(word_step(ACT_TICK, 1'b0, 1'b0));
		directed_steps.push_back(word_step(ACT_TICK, 1'b1, 1'b0));
		directed_steps.push_back(word_step(ACT_TICK, 1'b1, 1'b0));
		directed_steps.push_back(word_step(ACT_TICK, 1'b1, 1'b0));
		directed_steps.push_back(word_step(ACT_TICK, 1'b1, 1'b1));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_write) begin
				write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
			end else begin
				// Valid may stay high only if another word follows straight away.
				if (i + 1 < directed_steps.size() && !directed_steps[i + 1].is_write)
					gap = $urandom_range(0, 3);
				else
					gap = $urandom_range(1, 3);
				send_word(directed_steps[i].word, directed_steps[i].typed,
					directed_steps[i].want, gap);
			end
		end

		// Random phases. Each one starts only after the sender has waited for every
		// outstanding status word, then rewrites the registers with junk in the unused
		// upper data bits.
		pin_now = last_pin;
		run_left = 0;
		for (p = 0; p < PHASES; p++) begin
			mode = (p < 4) ? mode_t'(p[1:0]) : mode_t'($urandom_range(0, 3));
			deb = ($urandom_range(0, 3) == 0) ? '0 : DEBOUNCE_W'($urandom_range(1, 12));
			hnd = ($urandom_range(0, 3) != 0);
			case (p)
				1, 7: deb = '0;
				3: hnd = 1'b0;
				4: begin
					deb = 19'd1;
					hnd = 1'b1;
				end
				5: begin
					// Longest quiet time: waits open but cannot finish in this phase.
					deb = DEBOUNCE_MAX;
					mode = MODE_ANY;
				end
				6: begin
					// The wait left open above ends here with the mode off, so it fails.
					deb = 19'd3;
					mode = MODE_OFF;
				end
				9: deb = 19'd100;
				default: ;
			endcase
			mode_val = DEBOUNCE_W'($urandom);
			mode_val[MODE_W-1:0] = mode;
			hnd_val = DEBOUNCE_W'($urandom);
			hnd_val[0] = hnd;
			write_reg(CFG_TRIGGER_MODE, mode_val);
			write_reg(CFG_DEBOUNCE_US, deb);
			write_reg(CFG_HANDLER_PRESENT, hnd_val);
			if (p % 3 == 0) write_reg(CFG_UNUSED, DEBOUNCE_W'($urandom));

			stall_phase = (p == 2 || p == 8);
			no_idle = (p % 4 == 3);
			if (stall_phase) hold_request = 1'b1;
			words = (p == 5) ? 40 : 165;
			// Pin runs reach past the quiet time often enough for checks to pass, with
			// single-tick bounces mixed in.
			run_max = (deb > 120) ? 250 : 2 * int'(deb) + 3;

			for (n = 0; n < words; n++) begin
				w.pin_level = 1'($urandom_range(0, 1));
				w.sched_accept = ($urandom_range(0, 3) != 0);
				r = $urandom_range(0, 99);
				if (r < 3) begin
					w.action = ACT_CLEAR;
				end else if (r < 5) begin
					w.action = ACT_DISABLE;
				end else if ((!armed && r < 30) || r < 8) begin
					w.action = ACT_ENABLE;
				end else begin
					if (run_left == 0) begin
						pin_now = !pin_now;
						run_left = ($urandom_range(0, 9) < 3) ? 1 : $urandom_range(1, run_max);
					end
					run_left--;
					w.action = ACT_TICK;
					w.pin_level = pin_now;
				end
				if (n == words - 1)
					gap = $urandom_range(1, 3);
				else if (stall_phase || no_idle)
					gap = 0;
				else
					gap = $urandom_range(0, 3);
				send_word(w, 1'b0, '0, gap);
			end
		end
		no_idle = 1'b0;

		drain_status();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_status.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
